@@ src/dltq_pkg.sv @@
// Package for the delta-list timer queue: action and status codes, beat types.
// No dependencies.
package dltq_pkg;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned STAT_W  = 3;

  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RUN = 2'd2;

  localparam logic [STAT_W-1:0] ST_FIRED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTPEND = 3'd5;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   timer_id;
    logic [TICK_W-1:0] delay_ticks;
    logic [TICK_W-1:0] now_tick;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   result_id;
    logic              last;
  } out_beat_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture the input beat, read head slot and pending flag
    OP_ADD_STEP,  // compare remainder with current slot
    OP_DEL_STEP,  // compare id with current slot
    OP_RUN_STEP,  // compare elapsed with head slot
    OP_SHIFT_UP,  // move slot ptr-1 to ptr
    OP_SHIFT_DN,  // move slot ptr+1 to ptr
    OP_INSERT,    // write new timer at pos
    OP_FIX,       // apply delta fix-up at fix position
    OP_READ       // read slot at ptr
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             pend;      // addressed id is pending
    logic             full;      // queue holds DEPTH timers
    logic             at_end;    // pointer has reached entry count
    logic             hit;       // current comparison matched
    logic             shift_done;
    logic [ID_W-1:0]  id;        // id of the item or of the head slot
  } dp_stat_t;

endpackage

@@ src/dltq_if.sv @@
// Valid/ready channel carrying one payload beat.
// Depends on nothing; payload type is a parameter.
interface dltq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/delta_list_timer_queue_top.sv @@
// Top level of the delta-list timer queue: controller plus datapath.
// Depends on dltq_pkg, dltq_if, dltq_ctrl and dltq_dp.
//
//  channel | dir | payload                                   | beat
//  in_ch   | in  | action, timer_id, delay_ticks, now_tick    | one operation
//  out_ch  | out | status, result_id, last                   | one result
//
// An add walks the list and moves the later entries up; a delete walks, moves the
// later entries down and fixes up the successor's delta. A run fires due heads one
// by one, shifting the list down after each; shifts move one entry a cycle. Reset clears
// count, flags and last tick at once. A stalled result beat holds the controller; no
// input beat is taken until the last result of the current operation has been
// delivered.
module delta_list_timer_queue_top import dltq_pkg::*; #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_COUNT = 256
) (
  input logic clk,
  input logic rst,
  dltq_if.sink   in_ch,
  dltq_if.source out_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each operation.
  dltq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_beat (out_ch.data),
    .cmd, .stat
  );

  // Hold the list and do the arithmetic.
  dltq_dp #(.DEPTH(DEPTH), .ID_COUNT(ID_COUNT)) u_dp (
    .clk, .rst,
    .in_beat(in_ch.data),
    .cmd, .stat
  );

  // Last marks a result beat that ends the operation; fired beats never do.
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.status == ST_FIRED |-> !out_ch.data.last)
    else $error("fired beat marked last");
  // Never take an input beat while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while result pending");
endmodule

@@ src/dltq_dp.sv @@
// Datapath for the delta-list timer queue: slot memories, pending flags, walk pointer.
// Depends on dltq_pkg.
module dltq_dp import dltq_pkg::*; #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_COUNT = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  in_beat_t in_beat,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned ID_SPAN = 1 << ID_W;

  // Constant table that folds every raw id onto the id range.
  function automatic logic [ID_SPAN*ID_W-1:0] id_mod_table();
    logic [ID_SPAN*ID_W-1:0] t;
    for (int i = 0; i < ID_SPAN; i++) t[i*ID_W +: ID_W] = ID_W'(i % ID_COUNT);
    return t;
  endfunction

  localparam logic [ID_SPAN*ID_W-1:0] ID_MOD = id_mod_table();

  logic [ID_W-1:0]   mem_id    [DEPTH];
  logic [TICK_W-1:0] mem_delta [DEPTH];
  logic [ID_COUNT-1:0] pend;

  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     pos;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   id;
  logic [TICK_W-1:0] rem;
  logic [TICK_W-1:0] now;
  logic [TICK_W-1:0] last_run;
  logic [ID_W-1:0]   rd_id;
  logic [TICK_W-1:0] rd_delta;
  logic              pend_rd;
  logic              hit;
  logic              fix_add;
  logic [TICK_W-1:0] fix_val;

  logic [ID_W-1:0] id_red;
  logic [IW-1:0]   id_idx;
  logic [IW-1:0]   head_idx;
  always_comb begin
    id_red   = ID_MOD[in_beat.timer_id * ID_W +: ID_W];
    id_idx   = IW'(id);
    head_idx = IW'(rd_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      count    <= '0;
      last_run <= '0;
      ptr      <= '0;
      hit      <= 1'b0;
      fix_add  <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LATCH: begin
          action  <= in_beat.action;
          id      <= id_red;
          rem     <= (in_beat.action == ACT_RUN) ? in_beat.now_tick - last_run
                                                 : in_beat.delay_ticks;
          now     <= in_beat.now_tick;
          pend_rd <= pend[IW'(id_red)];
          ptr     <= '0;
          pos     <= count;
          hit     <= 1'b0;
          fix_add <= 1'b0;
          rd_id    <= mem_id[0];
          rd_delta <= mem_delta[0];
        end
        OP_READ: begin
          rd_id    <= mem_id[PW'(ptr)];
          rd_delta <= mem_delta[PW'(ptr)];
        end
        OP_ADD_STEP: begin
          if (rem <= rd_delta) begin
            hit     <= 1'b1;
            pos     <= ptr;
            fix_val <= rd_delta - rem;
            ptr     <= count;
          end else begin
            rem <= rem - rd_delta;
            ptr <= ptr + 1'b1;
          end
        end
        OP_DEL_STEP: begin
          if (rd_id == id) begin
            hit     <= 1'b1;
            pos     <= ptr;
            fix_val <= rd_delta;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        OP_RUN_STEP: begin
          // Head is always slot 0; fire it, the shift drops it.
          if (count != '0 && rd_delta <= rem) begin
            hit <= 1'b1;
            rem <= rem - rd_delta;
            pend[head_idx] <= 1'b0;
            ptr <= '0;
            pos <= '0;
          end else begin
            hit      <= 1'b0;
            last_run <= now;
            if (count != '0) mem_delta[0] <= rd_delta - rem;
          end
        end
        OP_SHIFT_UP: begin
          // ptr counts down from count to pos+1
          if (ptr > pos) begin
            mem_id[PW'(ptr)]    <= mem_id[PW'(ptr - 1'b1)];
            mem_delta[PW'(ptr)] <= mem_delta[PW'(ptr - 1'b1)];
            ptr <= ptr - 1'b1;
          end
        end
        OP_SHIFT_DN: begin
          if (ptr + 1'b1 < count) begin
            mem_id[PW'(ptr)]    <= mem_id[PW'(ptr + 1'b1)];
            mem_delta[PW'(ptr)] <= mem_delta[PW'(ptr + 1'b1)];
            ptr <= ptr + 1'b1;
          end else if (action == ACT_RUN) begin
            ptr   <= '0;
            count <= count - 1'b1;
          end
        end
        OP_INSERT: begin
          if (action == ACT_ADD) begin
            if (hit) mem_delta[PW'(pos + 1'b1)] <= fix_val;
            mem_id[PW'(pos)]    <= id;
            mem_delta[PW'(pos)] <= rem;
            count <= count + 1'b1;
            pend[id_idx] <= 1'b1;
          end else begin
            // Delete: entries already moved down; give delta to successor.
            if (hit) begin
              if (pos + 1'b1 < count) fix_add <= 1'b1;
              count <= count - 1'b1;
            end
            pend[id_idx] <= 1'b0;
            rd_delta <= mem_delta[PW'(pos)];
          end
        end
        OP_FIX: begin
          if (fix_add) mem_delta[PW'(pos)] <= rd_delta + fix_val;
          fix_add <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.action     = action;
    stat.pend       = pend_rd;
    stat.full       = (count >= CW'(DEPTH));
    stat.at_end     = (ptr >= count);
    stat.hit        = hit;
    stat.id         = (action == ACT_RUN) ? rd_id : id;
    unique case (cmd.op)
      OP_SHIFT_UP: stat.shift_done = !(ptr > pos);
      default:     stat.shift_done = !(ptr + 1'b1 < count);
    endcase
  end
endmodule

@@ src/dltq_ctrl.sv @@
// Controller for the delta-list timer queue: sequences walks, shifts and result beats.
// Depends on dltq_pkg.
module dltq_ctrl import dltq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat,
  output dp_cmd_t   cmd,
  input  dp_stat_t  stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WALK_RD, S_WALK, S_SHIFT, S_INSERT, S_FIX,
    S_RUN_RD, S_RUN, S_RUN_CHK, S_RUN_SHIFT, S_EMIT
  } state_t;

  state_t state, ret;

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.op   = OP_NONE;
    unique case (state)
      S_IDLE:      if (in_valid) cmd.op = OP_LATCH;
      S_WALK_RD:   cmd.op = OP_READ;
      S_WALK: begin
        if (stat.hit || stat.at_end) cmd.op = OP_NONE;
        else cmd.op = (stat.action == ACT_ADD) ? OP_ADD_STEP : OP_DEL_STEP;
      end
      S_SHIFT:     cmd.op = (stat.action == ACT_ADD) ? OP_SHIFT_UP : OP_SHIFT_DN;
      S_INSERT:    cmd.op = OP_INSERT;
      S_FIX:       cmd.op = OP_FIX;
      S_RUN_RD:    cmd.op = OP_READ;
      S_RUN:       cmd.op = OP_RUN_STEP;
      S_RUN_SHIFT: cmd.op = OP_SHIFT_DN;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          unique case (stat.action)
            ACT_ADD: begin
              if (stat.pend) begin
                out_beat <= '{ST_DUP, '0, 1'b1}; out_valid <= 1'b1;
                ret <= S_IDLE; state <= S_EMIT;
              end else if (stat.full) begin
                out_beat <= '{ST_FULL, '0, 1'b1}; out_valid <= 1'b1;
                ret <= S_IDLE; state <= S_EMIT;
              end else state <= stat.at_end ? S_SHIFT : S_WALK;
            end
            ACT_DEL: begin
              if (!stat.pend) begin
                out_beat <= '{ST_NOTPEND, '0, 1'b1}; out_valid <= 1'b1;
                ret <= S_IDLE; state <= S_EMIT;
              end else state <= stat.at_end ? S_INSERT : S_WALK;
            end
            ACT_RUN: state <= S_RUN;
            default: state <= S_IDLE;
          endcase
        end
        S_WALK_RD: state <= S_WALK;
        S_WALK: begin
          // The previous step's match or end of list leaves the walk.
          if (stat.hit || stat.at_end) state <= S_SHIFT;
          else state <= S_WALK_RD;
        end
        S_SHIFT: if (stat.shift_done) state <= S_INSERT;
        S_INSERT: begin
          if (stat.action == ACT_ADD) begin
            out_beat <= '{ST_ADDED, stat.id, 1'b1}; out_valid <= 1'b1;
            ret <= S_IDLE; state <= S_EMIT;
          end else state <= S_FIX;
        end
        S_FIX: begin
          out_beat <= '{ST_REMOVED, stat.id, 1'b1}; out_valid <= 1'b1;
          ret <= S_IDLE; state <= S_EMIT;
        end
        S_RUN_RD: state <= S_RUN;
        S_RUN: state <= S_RUN_CHK;
        S_RUN_CHK: begin
          if (stat.hit) begin
            out_beat <= '{ST_FIRED, stat.id, 1'b0};
            ret <= S_RUN_SHIFT;
          end else begin
            out_beat <= '{ST_DONE, '0, 1'b1};
            ret <= S_IDLE;
          end
          out_valid <= 1'b1;
          state <= S_EMIT;
        end
        S_RUN_SHIFT: if (stat.shift_done) state <= S_RUN_RD;
        S_EMIT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
